// File: src/damped_particle_integrator_2d_macros.svh
// Assertion macros for the damped 2D particle integrator.
// Used by the top level; each macro expects clk and arst_n in scope.
`ifndef DAMPED_PARTICLE_INTEGRATOR_2D_MACROS_SVH
`define DAMPED_PARTICLE_INTEGRATOR_2D_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DPI2D_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPI2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/dpi2d_pkg.sv
// Shared types, codes and fixed-point helpers of the damped 2D particle integrator.
// No dependencies; imported by the multiplier and the top level.
`default_nettype none

package dpi2d_pkg;

	// Field and port widths.
	localparam int VAL_W      = 32;
	localparam int OP_W       = 33;
	localparam int PROD_W     = 64;
	localparam int ACC_W      = 49;
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DT_W       = 16;
	localparam int DAMP_W     = 17;
	localparam int STEP_W     = 4;

	// Item kinds.
	localparam logic [IN_USER_W-1:0] KIND_FORCE    = 2'd0;
	localparam logic [IN_USER_W-1:0] KIND_TICK     = 2'd1;
	localparam logic [IN_USER_W-1:0] KIND_LOAD_POS = 2'd2;
	localparam logic [IN_USER_W-1:0] KIND_LOAD_VEL = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd2;

	// Register reset values.
	localparam logic [VAL_W-1:0]  INV_MASS_RST  = 32'd0;
	localparam logic [DT_W-1:0]   TIME_STEP_RST = 16'd1092;
	localparam logic [DAMP_W-1:0] DAMPING_RST   = 17'd65536;

	// Sequencer steps of a tick. Each step but the last issues one multiply, and
	// each step but the first consumes the product issued by the step before it.
	localparam logic [STEP_W-1:0] STEP_DT2 = 4'd0;
	localparam logic [STEP_W-1:0] STEP_AX  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_AY  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_VDX = 4'd3;
	localparam logic [STEP_W-1:0] STEP_ADX = 4'd4;
	localparam logic [STEP_W-1:0] STEP_AVX = 4'd5;
	localparam logic [STEP_W-1:0] STEP_VDY = 4'd6;
	localparam logic [STEP_W-1:0] STEP_ADY = 4'd7;
	localparam logic [STEP_W-1:0] STEP_AVY = 4'd8;
	localparam logic [STEP_W-1:0] STEP_DMX = 4'd9;
	localparam logic [STEP_W-1:0] STEP_DMY = 4'd10;
	localparam logic [STEP_W-1:0] STEP_SQX = 4'd11;
	localparam logic [STEP_W-1:0] STEP_SQY = 4'd12;
	localparam logic [STEP_W-1:0] STEP_FIN = 4'd13;

	// Top-level control states.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Clamp a 64-bit signed value to the signed 32-bit range.
	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	// Round half up of v / 2^16.
	function automatic logic signed [PROD_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + 64'sd32768;
		return t >>> 16;
	endfunction

	// Round half up of v / 2^17.
	function automatic logic signed [PROD_W-1:0] rnd17(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + 64'sd65536;
		return t >>> 17;
	endfunction

endpackage

`default_nettype wire

// File: src/dpi2d_mul.sv
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on dpi2d_pkg for operand and product widths.
`default_nettype none

module dpi2d_mul (
	input  wire logic                                  clk,
	input  wire logic signed [dpi2d_pkg::OP_W-1:0]     op_a,
	input  wire logic signed [dpi2d_pkg::OP_W-1:0]     op_b,
	output      logic signed [dpi2d_pkg::PROD_W-1:0]   prod_q
);
	import dpi2d_pkg::*;

	logic signed [2*OP_W-1:0] full;

	// Every product of the sequence fits in 64 signed bits.
	assign full = op_a * op_b;

	always_ff @(posedge clk) begin
		prod_q <= full[PROD_W-1:0];
	end

endmodule

`default_nettype wire

// File: src/damped_particle_integrator_2d.sv
// Damped Euler integrator of one 2D point mass in Q16.16 fixed point.
// Depends on dpi2d_pkg, dpi2d_mul and damped_particle_integrator_2d_macros.svh.
//
//   Channel   Signals                              Contents
//   s_axis    tvalid tready tdata[63:0] tuser[1:0]  force, tick or load request
//   m_axis    tvalid tready tdata[127:0] tuser[0]   tick result
//   cfg       valid ready index[1:0] data[31:0]     register write, always ready
//
// Force and load requests leave the sequencer idle. A tick runs 14
// sequencer steps around the one shared 33 x 33 multiplier (13 products),
// then loads the output register once that register is free.
// The input is ready only while the sequencer is idle; a result that is not
// taken holds the sequencer in its last state; an idle sequencer takes
// any request behind a pending result. Reset needs no clearing pass.
`default_nettype none
`include "damped_particle_integrator_2d_macros.svh"

module damped_particle_integrator_2d (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output      logic                                  s_axis_tready,
	// value_x [31:0], value_y [63:32]
	input  wire logic [dpi2d_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// kind [1:0]
	input  wire logic [dpi2d_pkg::IN_USER_W-1:0]       s_axis_tuser,
	output      logic                                  m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// position_x [31:0], position_y [63:32], velocity_x [95:64], velocity_y [127:96]
	output      logic [dpi2d_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// moved [0]
	output      logic [dpi2d_pkg::OUT_USER_W-1:0]      m_axis_tuser,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [dpi2d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [dpi2d_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dpi2d_pkg::*;

	state_t                  state_q;
	logic [STEP_W-1:0]       step_q;

	logic [VAL_W-1:0]        inv_mass_q;
	logic [DT_W-1:0]         time_step_q;
	logic [DAMP_W-1:0]       damping_q;

	logic signed [VAL_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic signed [VAL_W-1:0] force_x_q, force_y_q;

	// Tick scratch registers.
	logic [VAL_W-1:0]        dt2_q;
	logic signed [VAL_W-1:0] ax_q, ay_q, tx_q, ty_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [2*VAL_W-2:0]      sq_q;
	logic                    nz_q;
	logic                    moved_q;

	// Output register.
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic [OUT_USER_W-1:0]   out_user_q;

	logic signed [OP_W-1:0]   op_a, op_b;
	logic signed [PROD_W-1:0] prod_q;

	logic                    in_fire;
	logic                    out_load;
	logic signed [VAL_W-1:0] in_x, in_y;
	logic [PROD_W-1:0]       acc_ext;
	logic [PROD_W-1:0]       acc_sum;
	logic signed [VAL_W-1:0] new_pos;
	logic signed [VAL_W-1:0] new_vel_x, new_vel_y;
	logic signed [VAL_W-1:0] damped;
	logic [PROD_W-1:0]       sq_sum;
	logic                    below_one;

	assign in_x = s_axis_tdata[VAL_W-1:0];
	assign in_y = s_axis_tdata[2*VAL_W-1:VAL_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Shared multiplier.
	dpi2d_mul u_mul (
		.clk   (clk),
		.op_a  (op_a),
		.op_b  (op_b),
		.prod_q(prod_q)
	);

	// Operand selection for the multiply issued in each step.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (step_q)
			STEP_DT2: begin
				op_a = {17'd0, time_step_q};
				op_b = {17'd0, time_step_q};
			end
			STEP_AX: begin
				op_a = {force_x_q[VAL_W-1], force_x_q};
				op_b = {1'b0, inv_mass_q};
			end
			STEP_AY: begin
				op_a = {force_y_q[VAL_W-1], force_y_q};
				op_b = {1'b0, inv_mass_q};
			end
			STEP_VDX: begin
				op_a = {vel_x_q[VAL_W-1], vel_x_q};
				op_b = {17'd0, time_step_q};
			end
			STEP_ADX: begin
				op_a = {ax_q[VAL_W-1], ax_q};
				op_b = {1'b0, dt2_q};
			end
			STEP_AVX: begin
				op_a = {ax_q[VAL_W-1], ax_q};
				op_b = {17'd0, time_step_q};
			end
			STEP_VDY: begin
				op_a = {vel_y_q[VAL_W-1], vel_y_q};
				op_b = {17'd0, time_step_q};
			end
			STEP_ADY: begin
				op_a = {ay_q[VAL_W-1], ay_q};
				op_b = {1'b0, dt2_q};
			end
			STEP_AVY: begin
				op_a = {ay_q[VAL_W-1], ay_q};
				op_b = {17'd0, time_step_q};
			end
			STEP_DMX: begin
				op_a = {vel_x_q[VAL_W-1], vel_x_q};
				op_b = {16'd0, damping_q};
			end
			STEP_DMY: begin
				op_a = {vel_y_q[VAL_W-1], vel_y_q};
				op_b = {16'd0, damping_q};
			end
			STEP_SQX: begin
				op_a = {tx_q[VAL_W-1], tx_q};
				op_b = {tx_q[VAL_W-1], tx_q};
			end
			STEP_SQY: begin
				op_a = {ty_q[VAL_W-1], ty_q};
				op_b = {ty_q[VAL_W-1], ty_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Datapath around the product of the previous step.
	always_comb begin
		acc_ext   = {{(PROD_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
		acc_sum   = acc_ext + rnd17(prod_q);
		damped    = sat32(rnd16(prod_q));
		sq_sum    = {1'b0, sq_q} + {1'b0, prod_q[2*VAL_W-2:0]};
		below_one = (sq_sum[PROD_W-1:VAL_W] == '0);
		if (step_q == STEP_DMX) begin
			new_pos = sat32({{VAL_W{pos_y_q[VAL_W-1]}}, pos_y_q} + rnd16(acc_ext));
		end else begin
			new_pos = sat32({{VAL_W{pos_x_q[VAL_W-1]}}, pos_x_q} + rnd16(acc_ext));
		end
		new_vel_x = sat32({{VAL_W{vel_x_q[VAL_W-1]}}, vel_x_q} + rnd16(prod_q));
		new_vel_y = sat32({{VAL_W{vel_y_q[VAL_W-1]}}, vel_y_q} + rnd16(prod_q));
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q  <= INV_MASS_RST;
			time_step_q <= TIME_STEP_RST;
			damping_q   <= DAMPING_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INV_MASS:  inv_mass_q  <= cfg_data;
				REG_TIME_STEP: time_step_q <= cfg_data[DT_W-1:0];
				REG_DAMPING:   damping_q   <= cfg_data[DAMP_W-1:0];
				default:       ;
			endcase
		end
	end

	// Sequencer and particle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= STEP_DT2;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			vel_x_q   <= '0;
			vel_y_q   <= '0;
			force_x_q <= '0;
			force_y_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (s_axis_tuser)
							KIND_FORCE: begin
								force_x_q <= sat32({{VAL_W{force_x_q[VAL_W-1]}}, force_x_q}
									+ {{VAL_W{in_x[VAL_W-1]}}, in_x});
								force_y_q <= sat32({{VAL_W{force_y_q[VAL_W-1]}}, force_y_q}
									+ {{VAL_W{in_y[VAL_W-1]}}, in_y});
							end
							KIND_TICK: begin
								state_q <= ST_RUN;
								step_q  <= STEP_DT2;
							end
							KIND_LOAD_POS: begin
								pos_x_q <= in_x;
								pos_y_q <= in_y;
							end
							KIND_LOAD_VEL: begin
								vel_x_q <= in_x;
								vel_y_q <= in_y;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					step_q <= step_q + 4'd1;
					// Position and velocity of x, then of y.
					if (step_q == STEP_VDY) begin
						pos_x_q <= new_pos;
						vel_x_q <= new_vel_x;
					end
					if (step_q == STEP_DMX) begin
						pos_y_q <= new_pos;
						vel_y_q <= new_vel_y;
					end
					// Damping and cutoff land together.
					if (step_q == STEP_FIN) begin
						state_q   <= ST_DONE;
						force_x_q <= '0;
						force_y_q <= '0;
						if (nz_q) begin
							vel_x_q <= below_one ? '0 : tx_q;
							vel_y_q <= below_one ? '0 : ty_q;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scratch registers of a tick.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			unique case (step_q)
				STEP_AX:  dt2_q <= prod_q[VAL_W-1:0];
				STEP_AY:  ax_q  <= damped;
				STEP_VDX: ay_q  <= damped;
				STEP_ADX: acc_q <= prod_q[ACC_W-1:0];
				STEP_AVX: acc_q <= acc_sum[ACC_W-1:0];
				STEP_VDY: moved_q <= (new_pos != pos_x_q);
				STEP_ADY: acc_q <= prod_q[ACC_W-1:0];
				STEP_AVY: acc_q <= acc_sum[ACC_W-1:0];
				STEP_DMX: moved_q <= moved_q || (new_pos != pos_y_q);
				STEP_DMY: begin
					tx_q <= damped;
					nz_q <= (vel_x_q != '0) || (vel_y_q != '0);
				end
				STEP_SQX: ty_q <= damped;
				STEP_SQY: sq_q <= prod_q[2*VAL_W-2:0];
				default:  ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {vel_y_q, vel_x_q, pos_y_q, pos_x_q};
			out_user_q <= moved_q;
		end
	end

	// Checks.
	`DPI2D_ASSERT_NEXT(a_tick_starts, in_fire && (s_axis_tuser == KIND_TICK), (state_q == ST_RUN) && (step_q == STEP_DT2), "tick request did not start the sequencer")
	`DPI2D_ASSERT_IMP(a_result_from_done, $rose(m_axis_tvalid), $past(state_q == ST_DONE), "result raised outside the final state")
	`DPI2D_ASSERT_NEXT(a_force_cleared, out_load, (force_x_q == '0) && (force_y_q == '0), "force sum not cleared after a tick")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the damped 2D particle integrator.
// Depends on dpi2d_pkg and the top level; a built-in integrator predicts each tick result.
module tb_top;
	import dpi2d_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_REQUESTS = 215;

	typedef struct {
		logic [IN_USER_W-1:0] kind;
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] y;
	} request_t;

	typedef struct {
		logic signed [VAL_W-1:0] px;
		logic signed [VAL_W-1:0] py;
		logic signed [VAL_W-1:0] vx;
		logic signed [VAL_W-1:0] vy;
		logic moved;
	} tick_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [IN_USER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Requests waiting for the driver and tick results waiting for the monitor.
	request_t request_q[$];
	tick_result_t tick_results_q[$];
	request_t on_bus;
	bit bus_busy = 1'b0;

	// Integrator state and register copies of the predictor.
	logic signed [VAL_W-1:0] pos_x, pos_y, vel_x, vel_y, force_x, force_y;
	logic [VAL_W-1:0] inv_mass_r;
	logic [DT_W-1:0] step_r;
	logic [DAMP_W-1:0] damping_r;

	int src_idle_pct = 8;
	int snk_idle_pct = 80;
	int errors = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int ticks_sent = 0;
	int settings_used = 0;
	int stall_cycles = 0;

	damped_particle_integrator_2d u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp to the signed 32-bit range.
	function automatic logic signed [VAL_W-1:0] clamp_q16(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[VAL_W-1:0];
	endfunction

	// Round half up of v / 2^k.
	function automatic longint shift_round(input longint v, input int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic logic signed [VAL_W-1:0] accel_of(input logic signed [VAL_W-1:0] f);
		return clamp_q16(shift_round(longint'(f) * longint'({32'b0, inv_mass_r}), 16));
	endfunction

	function automatic logic signed [VAL_W-1:0] next_position(input logic signed [VAL_W-1:0] p,
			input logic signed [VAL_W-1:0] v, input logic signed [VAL_W-1:0] a);
		longint dt;
		longint d;
		dt = longint'({48'b0, step_r});
		d = longint'(v) * dt + shift_round(longint'(a) * (dt * dt), 17);
		return clamp_q16(longint'(p) + shift_round(d, 16));
	endfunction

	function automatic logic signed [VAL_W-1:0] next_velocity(input logic signed [VAL_W-1:0] v,
			input logic signed [VAL_W-1:0] a);
		return clamp_q16(longint'(v) + shift_round(longint'(a) * longint'({48'b0, step_r}), 16));
	endfunction

	function automatic logic signed [VAL_W-1:0] damped(input logic signed [VAL_W-1:0] v);
		return clamp_q16(shift_round(longint'(v) * longint'({47'b0, damping_r}), 16));
	endfunction

	function automatic longint unsigned square_of(input logic signed [VAL_W-1:0] v);
		longint unsigned m;
		m = (v < 0) ? longint'(-longint'(v)) : longint'(v);
		return m * m;
	endfunction

	// Apply one accepted request to the predicted state.
	task automatic integrate_request(input request_t r);
		tick_result_t res;
		logic signed [VAL_W-1:0] ax, ay;
		case (r.kind)
			KIND_FORCE: begin
				force_x = clamp_q16(longint'(force_x) + longint'(r.x));
				force_y = clamp_q16(longint'(force_y) + longint'(r.y));
			end
			KIND_LOAD_POS: begin
				pos_x = r.x;
				pos_y = r.y;
			end
			KIND_LOAD_VEL: begin
				vel_x = r.x;
				vel_y = r.y;
			end
			KIND_TICK: begin
				ax = accel_of(force_x);
				ay = accel_of(force_y);
				res.px = next_position(pos_x, vel_x, ax);
				res.py = next_position(pos_y, vel_y, ay);
				res.moved = (res.px != pos_x) || (res.py != pos_y);
				pos_x = res.px;
				pos_y = res.py;
				vel_x = next_velocity(vel_x, ax);
				vel_y = next_velocity(vel_y, ay);
				// Damping applies to a moving particle; slow motion is cut to rest.
				if (vel_x != 0 || vel_y != 0) begin
					vel_x = damped(vel_x);
					vel_y = damped(vel_y);
					if (square_of(vel_x) + square_of(vel_y) < 64'h1_0000_0000) begin
						vel_x = '0;
						vel_y = '0;
					end
				end
				force_x = '0;
				force_y = '0;
				res.vx = vel_x;
				res.vy = vel_y;
				tick_results_q.insert(tick_results_q.size(), res);
			end
		endcase
	endtask

	task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		$display("mismatch in result %0d, %s: expected %h, got %h", results_seen, what, want, got);
		errors++;
	endtask

	// Request driver: holds a request until the handshake, then picks the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				integrate_request(on_bus);
				bus_busy = 1'b0;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (request_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					on_bus = request_q.pop_front();
					bus_busy = 1'b1;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {on_bus.y, on_bus.x};
					s_axis_tuser <= on_bus.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		tick_result_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.px = m_axis_tdata[31:0];
				got.py = m_axis_tdata[63:32];
				got.vx = m_axis_tdata[95:64];
				got.vy = m_axis_tdata[127:96];
				got.moved = m_axis_tuser[0];
				if (tick_results_q.size() == 0) begin
					flag_mismatch("result with no tick pending", '0, got.px);
				end else begin
					want = tick_results_q.pop_front();
					if (got.px !== want.px) flag_mismatch("position_x", want.px, got.px);
					if (got.py !== want.py) flag_mismatch("position_y", want.py, got.py);
					if (got.vx !== want.vx) flag_mismatch("velocity_x", want.vx, got.vx);
					if (got.vy !== want.vy) flag_mismatch("velocity_y", want.vy, got.vy);
					if (got.moved !== want.moved) begin
						flag_mismatch("moved", 32'(want.moved), 32'(got.moved));
					end
				end
				results_seen++;
			end
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a handshake", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic push_req(input logic [IN_USER_W-1:0] kind, input logic [VAL_W-1:0] x,
			input logic [VAL_W-1:0] y);
		request_t r;
		r.kind = kind;
		r.x = x;
		r.y = y;
		request_q.insert(request_q.size(), r);
		requests_sent++;
		if (kind == KIND_TICK) ticks_sent++;
	endtask

	// One register write; the predictor copy follows at the handshake.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_INV_MASS: inv_mass_r = data;
			REG_TIME_STEP: step_r = data[DT_W-1:0];
			REG_DAMPING: damping_r = data[DAMP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] inv, input logic [CFG_DATA_W-1:0] dt,
			input logic [CFG_DATA_W-1:0] damp);
		write_reg(REG_INV_MASS, inv);
		write_reg(REG_TIME_STEP, dt);
		write_reg(REG_DAMPING, damp);
		settings_used++;
	endtask

	// Wait until every request is taken and every result has arrived, then let it settle.
	task automatic wait_idle();
		do @(posedge clk);
		while (request_q.size() != 0 || bus_busy || tick_results_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mix of extremes, full-range words, moderate values and speeds near the cutoff.
	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] mag;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'h0000_0001;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1, 2, 3: return $urandom();
			4, 5, 6: mag = $urandom_range(32'h0040_0000);
			7, 8: mag = 32'h0000_F000 + $urandom_range(32'h2000);
			default: mag = $urandom_range(32'h1000);
		endcase
		return $urandom_range(1) ? -mag : mag;
	endfunction

	// Mostly load, force and tick sequences; the rest is single requests of any kind.
	task automatic queue_random(input int n);
		int start;
		int k;
		start = requests_sent;
		while (requests_sent - start < n) begin
			if ($urandom_range(3) != 0) begin
				if ($urandom_range(1)) push_req(KIND_LOAD_POS, pick_value(), pick_value());
				if ($urandom_range(4) < 3) push_req(KIND_LOAD_VEL, pick_value(), pick_value());
				k = $urandom_range(3);
				repeat (k) push_req(KIND_FORCE, pick_value(), pick_value());
				k = $urandom_range(3, 1);
				repeat (k) push_req(KIND_TICK, $urandom(), $urandom());
			end else begin
				push_req(2'($urandom_range(3)), $urandom(), $urandom());
			end
		end
	endtask

	initial begin : stimulus
		int ph;
		pos_x = '0;
		pos_y = '0;
		vel_x = '0;
		vel_y = '0;
		force_x = '0;
		force_y = '0;
		inv_mass_r = INV_MASS_RST;
		step_r = TIME_STEP_RST;
		damping_r = DAMPING_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset register values: zero inverse mass leaves forces without effect.
		push_req(KIND_TICK, '0, '0);
		push_req(KIND_LOAD_VEL, 32'h0004_0000, 32'hFFFC_0000);
		push_req(KIND_FORCE, 32'h7FFF_FFFF, 32'h8000_0000);
		push_req(KIND_TICK, '0, '0);
		wait_idle();

		// Largest settings: saturation of the accumulator, position and velocity,
		// and damping above one.
		set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(KIND_LOAD_POS, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_req(KIND_LOAD_VEL, 32'h7FFF_FFFF, 32'h8000_0000);
		push_req(KIND_FORCE, 32'h7FFF_FFFF, 32'h8000_0000);
		push_req(KIND_FORCE, 32'h7FFF_FFFF, 32'h8000_0000);
		push_req(KIND_TICK, '0, '0);
		push_req(KIND_LOAD_POS, 32'h8000_0000, 32'h8000_0000);
		push_req(KIND_FORCE, 32'h8000_0000, 32'h7FFF_FFFF);
		push_req(KIND_FORCE, 32'h8000_0000, 32'h7FFF_FFFF);
		push_req(KIND_TICK, '0, '0);
		wait_idle();

		// Unit settings: cutoff below and at a speed of one, and a particle at rest.
		set_regs(32'h0001_0000, 32'd1092, 32'h0001_0000);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		push_req(KIND_LOAD_VEL, 32'h0000_8000, 32'hFFFF_8000);
		push_req(KIND_TICK, '0, '0);
		push_req(KIND_LOAD_VEL, 32'h0001_0000, 32'h0000_0000);
		push_req(KIND_TICK, '0, '0);
		push_req(KIND_LOAD_VEL, '0, '0);
		push_req(KIND_LOAD_POS, 32'h0000_0005, 32'hFFFF_FFFB);
		push_req(KIND_TICK, '0, '0);
		push_req(KIND_FORCE, 32'h0000_0001, 32'hFFFF_FFFF);
		push_req(KIND_TICK, '0, '0);
		wait_idle();

		// Random phases: three idling patterns, fixed and random register settings.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph / 3)
				0: begin
					src_idle_pct = 8;
					snk_idle_pct = 80;
				end
				1: begin
					src_idle_pct = 80;
					snk_idle_pct = 8;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			case (ph)
				0: set_regs(32'h0001_0000, 32'd1092, 32'h0001_0000);
				1: set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: set_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
				default: begin
					set_regs($urandom_range(2) == 0 ? $urandom() : $urandom_range(32'h0010_0000),
						$urandom(),
						$urandom_range(2) == 0 ? $urandom() : $urandom_range(65536, 58000));
					if (ph == 4) write_reg(REG_UNUSED, $urandom());
				end
			endcase
			queue_random(PHASE_REQUESTS);
			wait_idle();
		end

		$display("covered %0d requests, %0d of them ticks, under %0d register settings",
			requests_sent, ticks_sent, settings_used);
		$display("checked %0d tick results, %0d field mismatches", results_seen, errors);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
